FILE: rtl/segment_clip_aabb_3d_defines.svh
// Assertion macros for the segment clip block.
// Used by the top level only; no other dependencies.
`ifndef SEGMENT_CLIP_AABB_3D_DEFINES_SVH
`define SEGMENT_CLIP_AABB_3D_DEFINES_SVH

// Checked outside reset.
`define SCA3D_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked in every cycle, reset included.
`define SCA3D_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/sca3d_pkg.sv
// Package for the segment clip block: constants, payload types and register codes.
// No dependencies.
`default_nettype none
package sca3d_pkg;

   localparam int NUM_REGS      = 6;
   localparam int NUM_SLABS     = 6;
   localparam int DIV_STEPS     = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int CSR_IDX_W     = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BOX_MIN_X = 3'd0,
      REG_BOX_MAX_X = 3'd1,
      REG_BOX_MIN_Y = 3'd2,
      REG_BOX_MAX_Y = 3'd3,
      REG_BOX_MIN_Z = 3'd4,
      REG_BOX_MAX_Z = 3'd5
   } csr_index_type;

   localparam logic [31:0] BOX_RESET [NUM_REGS] = '{
      32'h0000_0000, 32'h0001_0000,
      32'h0000_0000, 32'h0001_0000,
      32'h0000_0000, 32'h0001_0000
   };

   // One divider lane: |q|*2^F / |p|, one quotient bit per cell.
   typedef struct packed {
      logic [32:0] divisor;
      logic [32:0] rem;
      logic [31:0] num_low;
      logic [31:0] quo;
      logic        ovf;
      logic        neg;
      logic        pzero;
      logic        qpos;
      logic        pneg;
   } div_lane_type;

   typedef struct packed {
      logic signed [31:0] r;
      logic               pzero;
      logic               qpos;
      logic               pneg;
   } slab_in_type;

   typedef struct packed {
      logic               ok;
      logic signed [31:0] lo;
      logic signed [31:0] hi;
   } clip_state_type;

endpackage
`default_nettype wire

FILE: rtl/sca3d_if.sv
// Valid/ready channel interfaces for the segment clip block: query in, result out.
// No dependencies.
`default_nettype none
interface sca3d_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] origin_x;
   logic signed [31:0] origin_y;
   logic signed [31:0] origin_z;
   logic signed [31:0] dir_x;
   logic signed [31:0] dir_y;
   logic signed [31:0] dir_z;
   logic signed [31:0] start_param;
   logic signed [31:0] end_param;

   modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   start_param, end_param, input ready);
   modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 start_param, end_param, output ready);
endinterface

interface sca3d_rsp_if;
   logic               valid;
   logic               ready;
   logic               hit;
   logic signed [31:0] clipped_start;
   logic signed [31:0] clipped_end;

   modport source (output valid, hit, clipped_start, clipped_end, input ready);
   modport sink (input valid, hit, clipped_start, clipped_end, output ready);
endinterface
`default_nettype wire

FILE: rtl/sca3d_div_cell.sv
// One restoring-division step: takes one quotient bit and hands the lane on.
// Depends on sca3d_pkg.
`default_nettype none
module sca3d_div_cell
   import sca3d_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         en,
   input  wire div_lane_type lane_in,
   output div_lane_type      lane_ff
);

   div_lane_type lane_in_n;
   logic [33:0]  trial;
   logic [33:0]  diff;
   logic         ge;

   always_comb begin
      trial     = {lane_in.rem, lane_in.num_low[31]};
      diff      = trial - {1'b0, lane_in.divisor};
      ge        = trial >= {1'b0, lane_in.divisor};
      lane_in_n = lane_in;
      lane_in_n.rem     = ge ? diff[32:0] : trial[32:0];
      lane_in_n.num_low = {lane_in.num_low[30:0], 1'b0};
      lane_in_n.quo     = {lane_in.quo[30:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in_n;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/sca3d_slab_cell.sv
// One slab test: narrows or rejects the parameter interval.
// Depends on sca3d_pkg.
`default_nettype none
module sca3d_slab_cell
   import sca3d_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           en,
   input  wire slab_in_type    slab,
   input  wire clip_state_type st_in,
   output clip_state_type      st_ff
);

   clip_state_type st_in_n;

   always_comb begin
      st_in_n = st_in;
      if (st_in.ok) begin
         if (slab.pzero) begin
            st_in_n.ok = !slab.qpos;
         end else if (slab.pneg) begin
            if (slab.r > st_in.hi) begin
               st_in_n.ok = 1'b0;
            end else if (slab.r > st_in.lo) begin
               st_in_n.lo = slab.r;
            end
         end else begin
            if (slab.r < st_in.lo) begin
               st_in_n.ok = 1'b0;
            end else if (slab.r < st_in.hi) begin
               st_in_n.hi = slab.r;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in_n;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/segment_clip_aabb_3d.sv
// Segment clip against a 3D axis-aligned box, Liang-Barsky, Q(32-F).F.
// Pipeline: 1 setup stage, 32 divider cells, 1 saturate stage, 6 slab cells.
// Throughput one item per cycle; the whole chain stalls only while a result waits.
// Reset (synchronous) empties the pipeline and loads the unit box.
// Depends on sca3d_pkg, sca3d_if, sca3d_div_cell, sca3d_slab_cell.
`default_nettype none
`include "segment_clip_aabb_3d_defines.svh"
module segment_clip_aabb_3d
   import sca3d_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)(
   input  wire logic                 clock,
   input  wire logic                 reset,
   sca3d_req_if.sink                 req,
   sca3d_rsp_if.source               rsp,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_wdata
);

   localparam int SH      = 32 - FRAC_BITS;
   localparam int NSTAGES = 1 + DIV_STEPS + 1 + NUM_SLABS;

   logic [31:0]        box_ff [NUM_REGS];
   logic [NSTAGES-1:0] v_ff;
   logic               adv;

   div_lane_type       dl [DIV_STEPS+1][NUM_SLABS];
   logic signed [31:0] lo_ff [DIV_STEPS+1];
   logic signed [31:0] hi_ff [DIV_STEPS+1];
   slab_in_type        si_ff [NUM_SLABS][NUM_SLABS];
   clip_state_type     st [NUM_SLABS+1];

   assign adv       = !v_ff[NSTAGES-1] || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            box_ff[i] <= BOX_RESET[i];
         end
      end else if (csr_we) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            if (csr_index == CSR_IDX_W'(i)) begin
               box_ff[i] <= csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NSTAGES-2:0], req.valid};
      end
   end

   // Setup: q, p per face, magnitudes, overflow test on the top quotient bits.
   logic signed [31:0] org [3];
   logic signed [31:0] dir [3];
   div_lane_type       dl0_in [NUM_SLABS];

   assign org[0] = req.origin_x;
   assign org[1] = req.origin_y;
   assign org[2] = req.origin_z;
   assign dir[0] = req.dir_x;
   assign dir[1] = req.dir_y;
   assign dir[2] = req.dir_z;

   always_comb begin
      logic signed [32:0] q;
      logic signed [32:0] p;
      logic [32:0]        mq;
      logic [32:0]        mp;
      logic [32:0]        rem0;
      for (int j = 0; j < NUM_SLABS; j++) begin
         if (j % 2 == 0) begin
            q = {box_ff[j][31], box_ff[j]} - {org[j/2][31], org[j/2]};
            p = -{dir[j/2][31], dir[j/2]};
         end else begin
            q = {org[j/2][31], org[j/2]} - {box_ff[j][31], box_ff[j]};
            p = {dir[j/2][31], dir[j/2]};
         end
         mq   = q[32] ? 33'(-q) : q;
         mp   = p[32] ? 33'(-p) : p;
         rem0 = mq >> SH;
         dl0_in[j].divisor = mp;
         dl0_in[j].rem     = rem0;
         dl0_in[j].num_low = mq[31:0] << FRAC_BITS;
         dl0_in[j].quo     = '0;
         dl0_in[j].ovf     = rem0 >= mp;
         dl0_in[j].neg     = q[32] == p[32];
         dl0_in[j].pzero   = p == '0;
         dl0_in[j].qpos    = !q[32] && (q != '0);
         dl0_in[j].pneg    = p[32];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dl[0]    <= dl0_in;
         lo_ff[0] <= req.start_param;
         hi_ff[0] <= req.end_param;
         for (int k = 1; k <= DIV_STEPS; k++) begin
            lo_ff[k] <= lo_ff[k-1];
            hi_ff[k] <= hi_ff[k-1];
         end
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      for (genvar j = 0; j < NUM_SLABS; j++) begin : g_lane
         sca3d_div_cell u_cell (
            .clock   (clock),
            .en      (adv),
            .lane_in (dl[k][j]),
            .lane_ff (dl[k+1][j])
         );
      end
   end

   // Saturate and apply sign.
   slab_in_type si_in [NUM_SLABS];

   always_comb begin
      div_lane_type l;
      for (int j = 0; j < NUM_SLABS; j++) begin
         l = dl[DIV_STEPS][j];
         if (l.neg) begin
            si_in[j].r = (l.ovf || (l.quo[31] && (l.quo[30:0] != '0))) ?
                         32'sh8000_0000 : -$signed(l.quo);
         end else begin
            si_in[j].r = (l.ovf || l.quo[31]) ? 32'sh7FFF_FFFF : $signed(l.quo);
         end
         si_in[j].pzero = l.pzero;
         si_in[j].qpos  = l.qpos;
         si_in[j].pneg  = l.pneg;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         si_ff[0] <= si_in;
         st[0]    <= '{ok: 1'b1, lo: lo_ff[DIV_STEPS], hi: hi_ff[DIV_STEPS]};
         for (int j = 1; j < NUM_SLABS; j++) begin
            si_ff[j] <= si_ff[j-1];
         end
      end
   end

   for (genvar j = 0; j < NUM_SLABS; j++) begin : g_slab
      sca3d_slab_cell u_cell (
         .clock (clock),
         .en    (adv),
         .slab  (si_ff[j][j]),
         .st_in (st[j]),
         .st_ff (st[j+1])
      );
   end

   assign rsp.valid         = v_ff[NSTAGES-1];
   assign rsp.hit           = st[NUM_SLABS].ok;
   assign rsp.clipped_start = st[NUM_SLABS].lo;
   assign rsp.clipped_end   = st[NUM_SLABS].hi;

   `SCA3D_ASSERT(a_stall_only_on_output, clock, reset, !req.ready |-> rsp.valid && !rsp.ready, "input stalled without a waiting result")
   `SCA3D_ASSERT_ALWAYS(a_empty_after_reset, clock, $past(reset) |-> !rsp.valid, "result valid right after reset")
   `SCA3D_ASSERT(a_chain_holds, clock, reset, !adv |=> $stable(v_ff), "pipeline moved during a stall")

endmodule
`default_nettype wire
